// ===== src/gbns_pkg.sv =====
// Shared types and constants of the go-back-N sender.
// No dependencies; the interfaces and the core import this package.
package gbns_pkg;

	localparam int SEQ_SPACE_DEF    = 8;
	localparam int PAYLOAD_BITS_DEF = 64;

	// Port field widths
	localparam int OP_W      = 2;
	localparam int DATA_W    = 64;
	localparam int SEQ_W     = 3;
	localparam int KIND_W    = 3;
	localparam int TIMER_W   = 2;
	localparam int WSIZE_W   = 3;
	localparam logic [WSIZE_W-1:0] WSIZE_RESET = 3'd4;

	typedef enum logic [OP_W-1:0] {
		OP_SEND    = 2'd0,
		OP_ACK     = 2'd1,
		OP_TIMEOUT = 2'd2
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PACKET       = 3'd0,
		KIND_REFUSED      = 3'd1,
		KIND_ACK_OK       = 3'd2,
		KIND_ACK_IGNORED  = 3'd3,
		KIND_TIMEOUT_IDLE = 3'd4
	} kind_t;

	typedef enum logic [TIMER_W-1:0] {
		TMR_NONE    = 2'd0,
		TMR_START   = 2'd1,
		TMR_STOP    = 2'd2,
		TMR_RESTART = 2'd3
	} timer_t;

	typedef enum logic {
		ST_IDLE,
		ST_REPLAY
	} state_t;

endpackage

// ===== src/gbns_if.sv =====
// Handshake channels of the go-back-N sender: request items in, result items out.
// Depends on gbns_pkg for field widths.
interface gbns_req_if import gbns_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [DATA_W-1:0]   payload;
	logic [SEQ_W-1:0]    ack_number;
	logic                ack_checksum_ok;

	modport source (output valid, operation, payload, ack_number, ack_checksum_ok,
		input ready);
	modport sink (input valid, operation, payload, ack_number, ack_checksum_ok,
		output ready);
endinterface

interface gbns_rsp_if import gbns_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [SEQ_W-1:0]    seq_number;
	logic [DATA_W-1:0]   packet_payload;
	logic [TIMER_W-1:0]  timer_action;
	logic                last;

	modport source (output valid, kind, seq_number, packet_payload, timer_action, last,
		input ready);
	modport sink (input valid, kind, seq_number, packet_payload, timer_action, last,
		output ready);
endinterface

// ===== src/go_back_n_sender_core.sv =====
// Go-back-N sender core: packet store in gbns_ram, window control, output register.
// Depends on gbns_pkg, gbns_if (request/result channels) and gbns_ram.
//
// A send or ack item yields one result item; a new item is accepted each cycle
// while the result register is free or being taken. A timeout with n packets
// outstanding replays them from the window base, one packet per cycle while the
// result register is free or being taken, set by the single read port of the packet
// store, whose read data is registered. No request item is accepted until the last
// replayed packet sits in the result register. A timeout with an empty window, like
// send and ack, yields one result.
// Write the window size through cfg_wr_en / cfg_wr_data only while idle; the block itself does not enforce this.
module go_back_n_sender_core import gbns_pkg::*; #(
	parameter int SEQ_SPACE    = SEQ_SPACE_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [WSIZE_W-1:0] cfg_wr_data,
	gbns_req_if.sink           req,
	gbns_rsp_if.source         rsp
);

	localparam int SW = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
	localparam int CW = ((SW > WSIZE_W) ? SW : WSIZE_W) + 1;
	localparam logic [SW-1:0] SEQ_MAX = SW'(SEQ_SPACE - 1);
	localparam logic [CW-1:0] LIMIT_MAX = CW'(SEQ_SPACE - 1);

	function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] x);
		return (x == SEQ_MAX) ? '0 : x + 1'b1;
	endfunction

	// distance from b forward to a, modulo the sequence space
	function automatic logic [SW-1:0] seq_dist(input logic [SW-1:0] a,
		input logic [SW-1:0] b);
		logic [SW:0] d;
		d = {1'b0, a} - {1'b0, b};
		if (a < b) begin
			d = d + (SW+1)'(SEQ_SPACE);
		end
		return d[SW-1:0];
	endfunction

	state_t state_q, state_nx;

	logic [WSIZE_W-1:0] window_size_q;
	logic [SW-1:0]      base_q;
	logic [SW-1:0]      next_seq_q;

	// replay walker
	logic [SW-1:0] rp_seq_q;
	logic [SW-1:0] rp_cnt_q;
	logic          rp_first_q;

	// read in flight / read data held in the RAM output register
	logic          rd_pend_s1;
	logic [SW-1:0] rd_seq_s1;
	logic          rd_first_s1;
	logic          rd_last_s1;

	logic                    out_valid_q;
	kind_t                   out_kind_q;
	logic [SEQ_W-1:0]        out_seq_q;
	logic [DATA_W-1:0]       out_data_q;
	timer_t                  out_timer_q;
	logic                    out_last_q;

	logic out_free;
	logic accept;
	logic rd_issue;
	logic rd_load;

	logic [SW-1:0]           count;
	logic [CW-1:0]           limit;
	logic                    full;
	logic [PAYLOAD_BITS-1:0] in_data;
	logic [SW-1:0]           ack_seq;
	logic                    ack_good;
	logic [SW-1:0]           new_base;
	logic [PAYLOAD_BITS-1:0] rd_data;

	logic                    ram_we;

	logic                    ld;
	kind_t                   ld_kind;
	logic [SEQ_W-1:0]        ld_seq;
	logic [DATA_W-1:0]       ld_data;
	timer_t                  ld_timer;

	assign out_free = !out_valid_q || rsp.ready;
	assign accept   = req.valid && req.ready;
	assign rd_load  = rd_pend_s1 && out_free;

	assign count    = seq_dist(next_seq_q, base_q);
	assign limit    = (CW'(window_size_q) > LIMIT_MAX) ? LIMIT_MAX : CW'(window_size_q);
	assign full     = CW'(count) >= limit;
	assign in_data  = req.payload[PAYLOAD_BITS-1:0];
	assign ack_seq  = SW'(req.ack_number);
	assign ack_good = req.ack_checksum_ok
		&& (CW'(req.ack_number) < CW'(SEQ_SPACE))
		&& (seq_dist(ack_seq, base_q) < count);
	assign new_base = seq_inc(ack_seq);
	assign ram_we   = accept && (op_t'(req.operation) == OP_SEND) && !full;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (op_t'(req.operation) == OP_TIMEOUT) && (count != '0)) begin
					state_nx = ST_REPLAY;
				end
			end
			ST_REPLAY: begin
				if (rd_issue && (rp_cnt_q == SW'(1))) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		req.ready = 1'b0;
		rd_issue  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = !rd_pend_s1 && out_free;
			end
			ST_REPLAY: begin
				rd_issue = !rd_pend_s1 || rd_load;
			end
			default: begin
				req.ready = 1'b0;
				rd_issue  = 1'b0;
			end
		endcase
	end

	// result for the output register
	always_comb begin
		ld       = 1'b0;
		ld_kind  = KIND_PACKET;
		ld_seq   = '0;
		ld_data  = '0;
		ld_timer = TMR_NONE;
		if (rd_load) begin
			ld       = 1'b1;
			ld_seq   = SEQ_W'(rd_seq_s1);
			ld_data  = DATA_W'(rd_data);
			ld_timer = rd_first_s1 ? TMR_RESTART : TMR_NONE;
		end else if (accept) begin
			case (op_t'(req.operation))
				OP_SEND: begin
					ld = 1'b1;
					if (full) begin
						ld_kind = KIND_REFUSED;
					end else begin
						ld_seq   = SEQ_W'(next_seq_q);
						ld_data  = DATA_W'(in_data);
						ld_timer = (count == '0) ? TMR_START : TMR_NONE;
					end
				end
				OP_ACK: begin
					ld = 1'b1;
					if (ack_good) begin
						ld_kind  = KIND_ACK_OK;
						ld_timer = (new_base == next_seq_q) ? TMR_STOP : TMR_RESTART;
					end else begin
						ld_kind = KIND_ACK_IGNORED;
					end
				end
				OP_TIMEOUT: begin
					// a non-empty window is answered by the replay
					if (count == '0) begin
						ld      = 1'b1;
						ld_kind = KIND_TIMEOUT_IDLE;
					end
				end
				default: ld = 1'b0;
			endcase
		end
	end

	gbns_ram #(
		.WIDTH (PAYLOAD_BITS),
		.DEPTH (SEQ_SPACE)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (next_seq_q),
		.wdata (in_data),
		.re    (rd_issue),
		.raddr (rp_seq_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			window_size_q <= WSIZE_RESET;
			base_q        <= '0;
			next_seq_q    <= '0;
			rp_seq_q      <= '0;
			rp_cnt_q      <= '0;
			rp_first_q    <= 1'b0;
			rd_pend_s1    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_wr_en) begin
				window_size_q <= cfg_wr_data;
			end

			if (ram_we) begin
				next_seq_q <= seq_inc(next_seq_q);
			end
			if (accept && (op_t'(req.operation) == OP_ACK) && ack_good) begin
				base_q <= new_base;
			end

			// start the walk at the window base
			if (accept && (op_t'(req.operation) == OP_TIMEOUT)) begin
				rp_seq_q   <= base_q;
				rp_cnt_q   <= count;
				rp_first_q <= 1'b1;
			end else if (rd_issue) begin
				rp_seq_q   <= seq_inc(rp_seq_q);
				rp_cnt_q   <= rp_cnt_q - 1'b1;
				rp_first_q <= 1'b0;
			end

			if (rd_issue) begin
				rd_pend_s1 <= 1'b1;
			end else if (rd_load) begin
				rd_pend_s1 <= 1'b0;
			end

			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_seq_s1   <= rp_seq_q;
			rd_first_s1 <= rp_first_q;
			rd_last_s1  <= (rp_cnt_q == SW'(1));
		end
		if (ld) begin
			out_kind_q  <= ld_kind;
			out_seq_q   <= ld_seq;
			out_data_q  <= ld_data;
			out_timer_q <= ld_timer;
			out_last_q  <= rd_load ? rd_last_s1 : 1'b1;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.kind           = out_kind_q;
	assign rsp.seq_number     = out_seq_q;
	assign rsp.packet_payload = out_data_q;
	assign rsp.timer_action   = out_timer_q;
	assign rsp.last           = out_last_q;

endmodule

// ===== src/gbns_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbns_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data while no read is issued
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
